[sv/rit_pkg.sv]
`timescale 1ns / 1ps
package rit_pkg;
	localparam int NUM_SLOTS = 16;
	localparam int TIME_W    = 32;
	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int STEP_W    = $clog2(TIME_W);

	// request codes
	localparam logic [1:0] REQ_REG    = 2'd0;
	localparam logic [1:0] REQ_DEL    = 2'd1;
	localparam logic [1:0] REQ_TICK   = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// result kinds
	localparam logic [2:0] KIND_REG   = 3'd0;
	localparam logic [2:0] KIND_FULL  = 3'd1;
	localparam logic [2:0] KIND_DEL   = 3'd2;
	localparam logic [2:0] KIND_FIRED = 3'd3;
	localparam logic [2:0] KIND_NONE  = 3'd4;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  slot;
		logic [7:0]  owner;
		logic [31:0] count;
		logic        expired;
		logic [4:0]  matched;
		logic        last;
	} result_t;
endpackage

[sv/repeating_interval_timer_bank.sv]
`timescale 1ns / 1ps
// Bank of timer slots driven by start/busy requests. A request of a known type is taken
// when start is high and busy is low; busy then stays high until the request is done.
// Register and delete requests walk the slots one per cycle. A tick walks the slots one
// per cycle and, for each due slot with a nonzero period, stops to run a shared restoring
// divider that gets elapsed / period. Results appear for one cycle on result_valid and
// cannot be held off by the receiver: a tick result is buffered until the next one (or
// the end of the scan) is known so that last can be set, and results always come in slot
// order.
module repeating_interval_timer_bank
	import rit_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [7:0]  owner_id,
	input  logic [31:0] next_delay,
	input  logic [31:0] period,
	input  logic [15:0] repeat_count,
	input  logic [31:0] now_time,
	output logic        result_valid,
	output logic [2:0]  kind,
	output logic [3:0]  slot,
	output logic [7:0]  fired_owner,
	output logic [31:0] fire_count,
	output logic        expired,
	output logic [4:0]  matched_count,
	output logic        last
);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]        state_q, state_d;
	logic [SLOT_W-1:0] idx_q;
	logic [1:0]        req_q;
	logic [7:0]        owner_q;
	logic [TIME_W-1:0] delay_q, per_q, now_q;
	logic [15:0]       rep_q;
	logic [4:0]        matched_q;

	// slot table
	logic [NUM_SLOTS-1:0] valid_q;
	logic [7:0]           tab_owner_q [NUM_SLOTS];
	logic [TIME_W-1:0]    tab_due_q   [NUM_SLOTS];
	logic [TIME_W-1:0]    tab_per_q   [NUM_SLOTS];
	logic [15:0]          tab_rep_q   [NUM_SLOTS];

	// shared divider
	logic [TIME_W-1:0] rem_q, quo_q;
	logic [STEP_W-1:0] step_q;
	logic [TIME_W:0]   trial;

	// pending tick result, held until we know whether it is the last one
	logic    pend_valid_q;
	result_t pend_q;
	result_t out_q;
	logic    out_valid_q;

	// current slot fields
	logic              cur_valid;
	logic [7:0]        cur_owner;
	logic [TIME_W-1:0] cur_due, cur_per, elapsed;
	logic [15:0]       cur_rep;
	logic              at_end;

	assign cur_valid = valid_q[idx_q];
	assign cur_owner = tab_owner_q[idx_q];
	assign cur_due   = tab_due_q[idx_q];
	assign cur_per   = tab_per_q[idx_q];
	assign cur_rep   = tab_rep_q[idx_q];
	assign elapsed   = now_q - cur_due;
	assign at_end    = (idx_q == SLOT_W'(NUM_SLOTS - 1));
	assign trial     = {rem_q, quo_q[TIME_W-1]} - {1'b0, cur_per};

	// firing result for the current slot, valid in scan (zero period) or at divider end
	logic              fire_now;
	logic [TIME_W-1:0] cnt_raw;
	logic [31:0]       cnt_out;
	logic              fire_free;
	logic [TIME_W-1:0] due_new;
	logic [15:0]       rep_new;
	logic              due_hit;

	assign due_hit = cur_valid && !elapsed[TIME_W-1];

	always_comb begin
		fire_now  = 1'b0;
		cnt_raw   = '0;
		cnt_out   = '0;
		fire_free = 1'b0;
		due_new   = cur_due;
		rep_new   = cur_rep;
		if (state_q == ST_SCAN && req_q == REQ_TICK && due_hit && cur_per == '0) begin
			fire_now = 1'b1;
			if (cur_rep != 16'd0) begin
				cnt_out   = 32'(cur_rep);
				fire_free = 1'b1;
			end else begin
				cnt_out = 32'hFFFF_FFFF;
			end
		end else if (state_q == ST_DIV && step_q == '0) begin
			fire_now = 1'b1;
			// last quotient bit folded in here
			cnt_raw = {quo_q[TIME_W-2:0], !trial[TIME_W]} + TIME_W'(1);
			if (cur_rep != 16'd0 && cnt_raw >= TIME_W'(cur_rep)) begin
				cnt_out   = 32'(cur_rep);
				fire_free = 1'b1;
			end else begin
				cnt_out = 32'(cnt_raw);
				// due + cnt*per == now - remainder + per
				due_new = now_q - (trial[TIME_W] ? {rem_q[TIME_W-2:0], quo_q[TIME_W-1]}
					: trial[TIME_W-1:0]) + cur_per;
				if (cur_rep != 16'd0)
					rep_new = cur_rep - cnt_raw[15:0];
			end
		end
	end

	// output selection
	logic    emit;
	result_t emit_r;
	result_t fire_r;
	logic    hit_del;

	assign hit_del = cur_valid && (cur_owner == owner_q);

	always_comb begin
		fire_r         = '0;
		fire_r.kind    = KIND_FIRED;
		fire_r.slot    = 4'(idx_q);
		fire_r.owner   = cur_owner;
		fire_r.count   = cnt_out;
		fire_r.expired = fire_free;
	end

	always_comb begin
		state_d = state_q;
		emit    = 1'b0;
		emit_r  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start && req_type != REQ_UNUSED)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				unique case (req_q)
					REQ_REG: begin
						if (!cur_valid) begin
							emit        = 1'b1;
							emit_r.kind = KIND_REG;
							emit_r.slot = 4'(idx_q);
							emit_r.last = 1'b1;
							state_d     = ST_IDLE;
						end else if (at_end) begin
							emit        = 1'b1;
							emit_r.kind = KIND_FULL;
							emit_r.last = 1'b1;
							state_d     = ST_IDLE;
						end
					end
					REQ_DEL: begin
						if (at_end) begin
							emit           = 1'b1;
							emit_r.kind    = KIND_DEL;
							emit_r.matched = matched_q + 5'(hit_del);
							emit_r.last    = 1'b1;
							state_d        = ST_IDLE;
						end
					end
					default: begin
						if (due_hit && cur_per != '0) begin
							state_d = ST_DIV;
						end else if (at_end) begin
							state_d = ST_FIN;
						end
						if (fire_now && pend_valid_q) begin
							emit   = 1'b1;
							emit_r = pend_q;
						end
					end
				endcase
			end
			ST_DIV: begin
				if (step_q == '0) begin
					state_d = at_end ? ST_FIN : ST_SCAN;
					if (pend_valid_q) begin
						emit   = 1'b1;
						emit_r = pend_q;
					end
				end
			end
			default: begin
				emit = 1'b1;
				if (pend_valid_q) begin
					emit_r      = pend_q;
					emit_r.last = 1'b1;
				end else begin
					emit_r.kind = KIND_NONE;
					emit_r.last = 1'b1;
				end
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			valid_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			matched_q    <= '0;
			step_q       <= '0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= emit;
			if (state_q == ST_IDLE) begin
				idx_q        <= '0;
				matched_q    <= '0;
				pend_valid_q <= 1'b0;
			end
			if (state_q == ST_SCAN) begin
				if (req_q == REQ_REG && !cur_valid)
					valid_q[idx_q] <= 1'b1;
				if (req_q == REQ_DEL && hit_del) begin
					valid_q[idx_q] <= 1'b0;
					matched_q      <= matched_q + 5'd1;
				end
				if (state_d == ST_SCAN)
					idx_q <= idx_q + SLOT_W'(1);
				if (state_d == ST_DIV)
					step_q <= STEP_W'(TIME_W - 1);
			end
			if (state_q == ST_DIV) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == '0 && !at_end)
					idx_q <= idx_q + SLOT_W'(1);
			end
			if (fire_now) begin
				pend_valid_q <= 1'b1;
				if (fire_free)
					valid_q[idx_q] <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			req_q   <= req_type;
			owner_q <= owner_id;
			delay_q <= TIME_W'(next_delay);
			per_q   <= TIME_W'(period);
			rep_q   <= repeat_count;
			now_q   <= TIME_W'(now_time);
		end
		if (state_q == ST_SCAN && req_q == REQ_REG && !cur_valid) begin
			tab_owner_q[idx_q] <= owner_q;
			tab_due_q[idx_q]   <= now_q + delay_q;
			tab_per_q[idx_q]   <= per_q;
			tab_rep_q[idx_q]   <= rep_q;
		end
		if (state_q == ST_SCAN && state_d == ST_DIV) begin
			rem_q <= '0;
			quo_q <= elapsed;
		end
		if (state_q == ST_DIV) begin
			if (!trial[TIME_W])
				rem_q <= trial[TIME_W-1:0];
			else
				rem_q <= {rem_q[TIME_W-2:0], quo_q[TIME_W-1]};
			quo_q <= {quo_q[TIME_W-2:0], !trial[TIME_W]};
		end
		if (fire_now) begin
			pend_q             <= fire_r;
			tab_due_q[idx_q]   <= due_new;
			tab_rep_q[idx_q]   <= rep_new;
		end
		if (emit)
			out_q <= emit_r;
	end

	assign busy          = (state_q != ST_IDLE);
	assign result_valid  = out_valid_q;
	assign kind          = out_q.kind;
	assign slot          = out_q.slot;
	assign fired_owner   = out_q.owner;
	assign fire_count    = out_q.count;
	assign expired       = out_q.expired;
	assign matched_count = out_q.matched;
	assign last          = out_q.last;

	// a request's results end with last and nothing follows in the next cycle
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |=> !result_valid)
		else $error("result right after last");

	// an accepted known request makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req_type != REQ_UNUSED |=> busy)
		else $error("accepted request did not start");

	// only fired results may come without last
	a_nonlast_fired: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> kind == KIND_FIRED)
		else $error("non-final result that is not a firing");

endmodule
